### hw/rtl/pdt_pkg.sv
// shared types and constants of the periodic task dispatcher
`default_nettype none

package pdt_pkg;

  localparam int unsigned MAX_SLOTS = 16;
  localparam int unsigned SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_PERIOD   = 2'd1,
    REQ_REMOVE   = 2'd2,
    REQ_CHECK    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_DISPATCH = 3'd3,
    ST_NONE_DUE = 3'd4
  } status_e;

  typedef struct packed {
    logic        op_reg;
    logic        op_per;
    logic        op_rem;
    logic        op_chk;
    logic        shift;
    logic [31:0] period;
    logic [31:0] now;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;
    logic token;
    logic hit;
  } cell_sts_t;

endpackage

`default_nettype wire

### hw/rtl/pdt_if.sv
// request and result stream interfaces
`default_nettype none

interface pdt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [3:0]  task_slot;
  logic [31:0] period_ms;
  logic [31:0] now_ms;

  modport source (output valid, req_type, task_slot, period_ms, now_ms, input ready);
  modport sink   (input valid, req_type, task_slot, period_ms, now_ms, output ready);
endinterface

interface pdt_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] due_slot;
  logic       last_of_run;

  modport source (output valid, status, due_slot, last_of_run, input ready);
  modport sink   (input valid, status, due_slot, last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/pdt_cell.sv
// one task slot of the dispatcher chain
`default_nettype none

module pdt_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pdt_pkg::cell_cmd_t cmd_i,
  input  wire logic              sel_i,
  input  wire logic              token_i,
  output pdt_pkg::cell_sts_t     sts_o
);

  logic        valid_q, valid_d;
  logic        token_q, token_d;
  logic        due_q, due_d;
  logic [31:0] period_q, period_d;
  logic [31:0] last_q, last_d;
  logic [31:0] elapsed;
  logic        due_now;

  assign elapsed = cmd_i.now - last_q;
  assign due_now = valid_q && (elapsed >= period_q);

  always_comb begin
    valid_d  = valid_q;
    period_d = period_q;
    last_d   = last_q;
    due_d    = due_q;
    token_d  = cmd_i.shift ? token_i : token_q;
    if (cmd_i.op_reg && sel_i) begin
      valid_d  = 1'b1;
      period_d = cmd_i.period;
      last_d   = '0;
    end
    if (cmd_i.op_per && sel_i) begin
      period_d = cmd_i.period;
    end
    if (cmd_i.op_rem && sel_i) begin
      valid_d = 1'b0;
    end
    if (cmd_i.op_chk) begin
      due_d = due_now;
      if (due_now) begin
        last_d = cmd_i.now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      token_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      token_q <= token_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    last_q   <= last_d;
    due_q    <= due_d;
  end

  assign sts_o.valid = valid_q;
  assign sts_o.token = token_q;
  assign sts_o.hit   = token_q & due_q;

endmodule

`default_nettype wire

### hw/rtl/periodic_task_dispatcher_core.sv
// periodic task dispatcher: slot cell chain with walk sequencer
// register, set period and remove: one result, in the cycle after the transfer
// check: all slots compared at the transfer, then a token walks the chain
// one slot a cycle, held while a due result waits on a stalled output;
// results trail the walk
// reset clears all valid bits, the task count and the sequencer
`default_nettype none

module periodic_task_dispatcher_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pdt_req_if.sink    req_i,
  pdt_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_e;

  localparam int unsigned N  = pdt_pkg::MAX_SLOTS;
  localparam int unsigned SW = pdt_pkg::SLOT_W;
  localparam int unsigned CW = pdt_pkg::CNT_W;

  state_e                 state_q, state_d;
  logic [SW-1:0]          idx_q, idx_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [SW-1:0]          pend_slot_q, pend_slot_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   out_valid_q, out_valid_d;
  logic [2:0]             status_q, status_d;
  logic [3:0]             slot_q, slot_d;
  logic                   last_q, last_d;

  pdt_pkg::cell_cmd_t     cmd;
  pdt_pkg::cell_sts_t     sts [N];
  logic [N-1:0]           sel_vec;
  logic [N-1:0]           valid_vec;
  logic [N-1:0]           token_vec;
  logic [N-1:0]           chain;

  logic accept, out_free, in_table, full, empty, sel_valid, hit, adv, start;
  logic is_reg, is_per, is_rem, is_chk;

  assign out_free     = !out_valid_q || rsp_o.ready;
  assign req_i.ready  = (state_q == S_IDLE) && out_free;
  assign accept       = req_i.valid && req_i.ready;
  assign in_table     = 32'(req_i.task_slot) < N;
  assign full         = count_q == CW'(N);
  assign empty        = count_q == '0;
  assign is_reg       = req_i.req_type == pdt_pkg::REQ_REGISTER;
  assign is_per       = req_i.req_type == pdt_pkg::REQ_PERIOD;
  assign is_rem       = req_i.req_type == pdt_pkg::REQ_REMOVE;
  assign is_chk       = req_i.req_type == pdt_pkg::REQ_CHECK;
  assign start        = accept && is_chk;

  assign chain[0] = start;

  for (genvar j = 0; j < N; j++) begin : g_cell
    assign sel_vec[j]   = 32'(req_i.task_slot) == 32'(j);
    assign valid_vec[j] = sts[j].valid;
    assign token_vec[j] = sts[j].token;
    if (j < N - 1) begin : g_link
      assign chain[j+1] = sts[j].token;
    end

    pdt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sel_i   (sel_vec[j]),
      .token_i (chain[j]),
      .sts_o   (sts[j])
    );
  end

  always_comb begin
    sel_valid = 1'b0;
    hit       = 1'b0;
    for (int j = 0; j < N; j++) begin
      sel_valid = sel_valid | (sel_vec[j] & sts[j].valid);
      hit       = hit | sts[j].hit;
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    status_d     = status_q;
    slot_d       = slot_q;
    last_d       = last_q;
    adv          = 1'b0;

    cmd.op_reg = accept && is_reg && !full && in_table;
    cmd.op_per = accept && is_per && in_table;
    cmd.op_rem = accept && is_rem && !empty && in_table;
    cmd.op_chk = start;
    cmd.period = req_i.period_ms;
    cmd.now    = req_i.now_ms;

    if (cmd.op_reg && !sel_valid) begin
      count_d = count_q + 1'b1;
    end
    if (cmd.op_rem && sel_valid) begin
      count_d = count_q - 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_chk) begin
            state_d      = S_WALK;
            idx_d        = '0;
            pend_valid_d = 1'b0;
          end else begin
            out_valid_d = 1'b1;
            slot_d      = '0;
            last_d      = 1'b1;
            if (is_reg && full) begin
              status_d = pdt_pkg::ST_FULL;
            end else if (is_rem && empty) begin
              status_d = pdt_pkg::ST_EMPTY;
            end else begin
              status_d = pdt_pkg::ST_DONE;
            end
          end
        end
      end
      S_WALK: begin
        adv = 1'b1;
        if (hit) begin
          if (pend_valid_q) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              status_d    = pdt_pkg::ST_DISPATCH;
              slot_d      = 4'(pend_slot_q);
              last_d      = 1'b0;
              pend_slot_d = idx_q;
            end else begin
              adv = 1'b0;
            end
          end else begin
            pend_valid_d = 1'b1;
            pend_slot_d  = idx_q;
          end
        end
        if (adv) begin
          if (idx_q == SW'(N - 1)) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = SW'(idx_q + 1'b1);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          if (pend_valid_q) begin
            status_d = pdt_pkg::ST_DISPATCH;
            slot_d   = 4'(pend_slot_q);
          end else begin
            status_d = pdt_pkg::ST_NONE_DUE;
            slot_d   = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    cmd.shift = start || adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_slot_q  <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= '0;
      slot_q       <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_valid_q <= pend_valid_d;
      pend_slot_q  <= pend_slot_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      status_q     <= status_d;
      slot_q       <= slot_d;
      last_q       <= last_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.due_slot    = slot_q;
  assign rsp_o.last_of_run = last_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_vec))
    else $error("task count differs from valid slots");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token_vec))
    else $error("more than one token in the chain");

  a_hit_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (state_q == S_WALK))
    else $error("slot hit outside a walk");

  a_token_tracks_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> token_vec[idx_q])
    else $error("token not at walk index");

endmodule

`default_nettype wire

### bench/tb.sv
// testbench of the periodic task dispatcher: table of directed requests, then random episodes
`timescale 1ns / 100ps

module tb;
  import pdt_pkg::*;

  localparam int RAND_ITEMS = 410;
  localparam int CALM_ITEMS = 80;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_WAIT  = MAX_SLOTS + 6;
  localparam int DIR_ROWS   = 23;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot;
    logic       last;
  } rsp_t;

  typedef struct packed {
    req_e        req;
    logic [3:0]  slot;
    logic [31:0] per;
    logic [31:0] now;
    logic        typed;
    status_e     est;
    logic [3:0]  eslot;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pdt_req_if req_if ();
  pdt_rsp_if rsp_if ();

  periodic_task_dispatcher_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always #2 clk = ~clk;

  // predictor state
  logic        slot_on   [MAX_SLOTS];
  logic [31:0] slot_per  [MAX_SLOTS];
  logic [31:0] slot_last [MAX_SLOTS];
  int          slot_cnt;

  rsp_t step_res [MAX_SLOTS];
  rsp_t pending_rsp [$];

  int  mismatch_cnt = 0;
  int  rsp_checked = 0;
  int  idle_cycles = 0;
  int  req_seen [4];
  int  n_dispatch = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  n_none_due = 0;
  bit  calm = 1'b0;

  function automatic int predict_dispatch(req_e r, logic [3:0] s, logic [31:0] per,
                                          logic [31:0] now);
    int n;
    logic [31:0] diff;
    status_e st;
    n = 0;
    st = ST_DONE;
    case (r)
      REQ_CHECK: begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
          diff = now - slot_last[i];
          if (slot_on[i] && diff >= slot_per[i]) begin
            slot_last[i] = now;
            step_res[n].status = ST_DISPATCH;
            step_res[n].slot   = 4'(i);
            step_res[n].last   = 1'b0;
            n++;
          end
        end
        if (n == 0) begin
          step_res[0].status = ST_NONE_DUE;
          step_res[0].slot   = '0;
          step_res[0].last   = 1'b1;
          return 1;
        end
        step_res[n-1].last = 1'b1;
        return n;
      end
      REQ_REGISTER: begin
        if (slot_cnt >= MAX_SLOTS) begin
          st = ST_FULL;
        end else if (s < MAX_SLOTS) begin
          if (!slot_on[s]) begin
            slot_on[s] = 1'b1;
            slot_cnt++;
          end
          slot_per[s]  = per;
          slot_last[s] = '0;
        end
      end
      REQ_PERIOD: begin
        if (s < MAX_SLOTS) slot_per[s] = per;
      end
      default: begin
        if (slot_cnt == 0) begin
          st = ST_EMPTY;
        end else if (s < MAX_SLOTS && slot_on[s]) begin
          slot_on[s] = 1'b0;
          slot_cnt--;
        end
      end
    endcase
    step_res[0].status = st;
    step_res[0].slot   = '0;
    step_res[0].last   = 1'b1;
    return 1;
  endfunction

  function automatic logic [3:0] pick_slot(logic want_on);
    logic [3:0] cand [$];
    for (int i = 0; i < MAX_SLOTS; i++)
      if (slot_on[i] == want_on) cand.push_back(4'(i));
    if (cand.size() == 0 || $urandom_range(0, 6) == 0) return 4'($urandom_range(0, 15));
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // starts and ends at a falling edge
  task automatic send_req(req_e r, logic [3:0] s, logic [31:0] per, logic [31:0] now,
                          logic typed, status_e est, logic [3:0] eslot);
    int n;
    rsp_t t;
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_if.req_type  = r;
    req_if.task_slot = s;
    req_if.period_ms = per;
    req_if.now_ms    = now;
    req_if.valid     = 1'b1;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    n = predict_dispatch(r, s, per, now);
    req_seen[r]++;
    if (typed) begin
      t.status = est;
      t.slot   = eslot;
      t.last   = 1'b1;
      pending_rsp.push_back(t);
    end else begin
      for (int i = 0; i < n; i++) pending_rsp.push_back(step_res[i]);
    end
    for (int i = 0; i < n; i++) begin
      case (step_res[i].status)
        ST_DISPATCH: n_dispatch++;
        ST_FULL:     n_full++;
        ST_EMPTY:    n_empty++;
        ST_NONE_DUE: n_none_due++;
        default: ;
      endcase
    end
    @(negedge clk);
  endtask

  // result side: random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  // result checking and progress watchdog
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = status_e'(rsp_if.status);
        got.slot   = rsp_if.due_slot;
        got.last   = rsp_if.last_of_run;
        if (pending_rsp.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t unexpected result status=%0d slot=%0d last=%0b",
                     $realtime, got.status, got.slot, got.last);
        end else begin
          want = pending_rsp.pop_front();
          rsp_checked++;
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t mismatch: expected status=%0d slot=%0d last=%0b, got status=%0d slot=%0d last=%0b",
                       $realtime, want.status, want.slot, want.last,
                       got.status, got.slot, got.last);
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAIL periodic_task_dispatcher_core");
    $finish;
  end

  initial begin
    row_t        dir_tab [DIR_ROWS];
    int          mode;
    int          ep_len;
    int          done_items;
    int          pick;
    req_e        r;
    logic [3:0]  s;
    logic [31:0] per;
    logic [31:0] now;
    logic [31:0] now_cursor;

    dir_tab = '{
      '{REQ_REMOVE,   4'd0,  32'd0,          32'd0,          1'b1, ST_EMPTY,    4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'd0,          1'b1, ST_NONE_DUE, 4'd0},
      '{REQ_PERIOD,   4'd5,  32'd7,          32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_REGISTER, 4'd0,  32'd0,          32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'd0,          1'b1, ST_DISPATCH, 4'd0},
      '{REQ_REGISTER, 4'd15, 32'hFFFF_FFFF,  32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'hFFFF_FFFE,  1'b0, ST_DONE,     4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'hFFFF_FFFF,  1'b0, ST_DONE,     4'd0},
      '{REQ_REGISTER, 4'd0,  32'd100,        32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_REGISTER, 4'd3,  32'd10,         32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'hFFFF_FFF8,  1'b0, ST_DONE,     4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'd1,          1'b0, ST_DONE,     4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'd2,          1'b0, ST_DONE,     4'd0},
      '{REQ_REMOVE,   4'd7,  32'd0,          32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_REMOVE,   4'd3,  32'd0,          32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_PERIOD,   4'd0,  32'd0,          32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'h5555_AAAA,  1'b0, ST_DONE,     4'd0},
      '{REQ_REGISTER, 4'd10, 32'hAAAA_5555,  32'hFFFF_FFFF,  1'b1, ST_DONE,     4'd0},
      '{REQ_REMOVE,   4'd15, 32'hFFFF_FFFF,  32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_REMOVE,   4'd0,  32'd0,          32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_REMOVE,   4'd10, 32'd0,          32'd0,          1'b1, ST_DONE,     4'd0},
      '{REQ_REMOVE,   4'd10, 32'd0,          32'd0,          1'b1, ST_EMPTY,    4'd0},
      '{REQ_CHECK,    4'd0,  32'd0,          32'd123,        1'b1, ST_NONE_DUE, 4'd0}
    };

    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_on[i]   = 1'b0;
      slot_per[i]  = '0;
      slot_last[i] = '0;
    end
    slot_cnt = 0;
    for (int i = 0; i < 4; i++) req_seen[i] = 0;

    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_REGISTER;
    req_if.task_slot = '0;
    req_if.period_ms = '0;
    req_if.now_ms    = '0;

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_req(dir_tab[i].req, dir_tab[i].slot, dir_tab[i].per, dir_tab[i].now,
               dir_tab[i].typed, dir_tab[i].est, dir_tab[i].eslot);

    // random episodes: fill, drain, mixed, check-heavy
    now_cursor = $urandom_range(0, 3) == 0 ? 32'hFFFF_FF00 : 32'd200;
    done_items = 0;
    while (done_items < RAND_ITEMS) begin
      mode   = $urandom_range(0, 3);
      ep_len = $urandom_range(10, 40);
      for (int k = 0; k < ep_len && done_items < RAND_ITEMS; k++) begin
        calm = (done_items >= RAND_ITEMS - CALM_ITEMS);
        pick = $urandom_range(0, 99);
        case (mode)
          0: r = pick < 60 ? REQ_REGISTER : pick < 90 ? REQ_CHECK :
                 pick < 95 ? REQ_PERIOD : REQ_REMOVE;
          1: r = pick < 55 ? REQ_REMOVE : pick < 90 ? REQ_CHECK :
                 pick < 95 ? REQ_PERIOD : REQ_REGISTER;
          2: r = req_e'($urandom_range(0, 3));
          default: r = pick < 70 ? REQ_CHECK : REQ_PERIOD;
        endcase
        case (r)
          REQ_REGISTER: s = $urandom_range(0, 99) < 85 ? pick_slot(1'b0)
                                                       : 4'($urandom_range(0, 15));
          REQ_REMOVE:   s = $urandom_range(0, 99) < 85 ? pick_slot(1'b1)
                                                       : 4'($urandom_range(0, 15));
          REQ_PERIOD:   s = $urandom_range(0, 1) == 0 ? pick_slot(1'b1)
                                                      : 4'($urandom_range(0, 15));
          default:      s = 4'($urandom_range(0, 15));
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0)      per = '0;
        else if (pick == 1) per = 32'hFFFF_FFFF;
        else if (pick < 4)  per = $urandom;
        else                per = $urandom_range(0, 60);
        if (r == REQ_CHECK) begin
          if ($urandom_range(0, 15) == 0) now_cursor = $urandom;
          else now_cursor = now_cursor + $urandom_range(0, 40);
          now = now_cursor;
        end else begin
          now = $urandom;
        end
        send_req(r, s, per, now, 1'b0, ST_DONE, 4'd0);
        done_items++;
      end
    end
    req_if.valid = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("requests: register %0d, set period %0d, remove %0d, check %0d; %0d results checked",
             req_seen[REQ_REGISTER], req_seen[REQ_PERIOD], req_seen[REQ_REMOVE],
             req_seen[REQ_CHECK], rsp_checked);
    $display("dispatches %0d, nothing due %0d, full refusals %0d, empty refusals %0d, mismatches %0d",
             n_dispatch, n_none_due, n_full, n_empty, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0)
      $display("PASS periodic_task_dispatcher_core");
    else
      $display("FAIL periodic_task_dispatcher_core");
    $finish;
  end

endmodule
